@@ sv/bcpd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the battery-compensated PWM drive.
// No dependencies; imported by battery_compensated_pwm_drive.

package bcpd_pkg;

	// Item operation codes.
	typedef enum logic [1:0] {
		OP_SET    = 2'd0,
		OP_OFF    = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_PWM_MAX    = 2'd0,
		CFG_VOTE_LIMIT = 2'd1,
		CFG_BAND_ABOVE = 2'd2,
		CFG_BAND_BELOW = 2'd3
	} cfg_idx_t;

	// Fixed field widths.
	localparam int LEVEL_W = 11;
	localparam int VOTE_W  = 6;
	localparam int BAND_W  = 8;
	localparam int CMP_W   = 9;
	localparam int CFG_W   = 11;

	// Register reset values.
	localparam logic [LEVEL_W-1:0] PWM_MAX_RST    = 11'd2040;
	localparam logic [VOTE_W-1:0]  VOTE_LIMIT_RST = 6'd20;
	localparam logic [BAND_W-1:0]  BAND_ABOVE_RST = 8'd5;
	localparam logic [BAND_W-1:0]  BAND_BELOW_RST = 8'd2;

	// Targets below this value bypass battery correction.
	localparam int SMALL_TARGET = 8;

endpackage

@@ sv/battery_compensated_pwm_drive.sv @@
`timescale 1ns / 1ps
// Battery-compensated PWM LED drive: control, battery tracking and serial divider.
// Depends on bcpd_pkg.
//
// Usage: one input channel (in_valid / in_stall) carries op, target_level and
// battery_sample; every accepted item yields exactly one result on the output
// channel (out_valid / out_stall) holding compare_value and drive_level.
// A separate write channel (cfg_valid / cfg_ready, always ready) updates the
// four configuration registers; write them only while the block is idle.
// Set, off and tick items produce their result in the cycle after the transfer.
// A battery sample runs a tracking step, a band step, a restoring divider that
// yields TARGET_BITS quotient bits (one quotient bit per cycle), a saturation
// step and an output step; with the drive off or a small target it skips the
// band and divider steps, and with a zero divisor it skips the divider step.
// Only one item is in flight; the next item can be taken in the cycle after
// the result is loaded, so no new item is taken while a sample is processed.
// Reset clears all state, loads the register defaults and empties the output.
// When the receiver stalls, the result holds in the output register and the
// input is stalled until that result transfers.

module battery_compensated_pwm_drive #(
	parameter int SAMPLE_BITS = 10,
	parameter int TARGET_BITS = 24,
	parameter int DITHER_BITS = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input item channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bcpd_pkg::op_t                 op,
	input  logic [TARGET_BITS-1:0]        target_level,
	input  logic [SAMPLE_BITS-1:0]        battery_sample,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bcpd_pkg::CMP_W-1:0]    compare_value,
	output logic [bcpd_pkg::LEVEL_W-1:0]  drive_level,
	// Configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  bcpd_pkg::cfg_idx_t            cfg_index,
	input  logic [bcpd_pkg::CFG_W-1:0]    cfg_data
);
	import bcpd_pkg::*;

	localparam int CNT_W  = (TARGET_BITS > 1) ? $clog2(TARGET_BITS) : 1;
	localparam int VC_W   = VOTE_W + 1;
	localparam int VX_W   = VOTE_W + 2;
	localparam int BW     = ((SAMPLE_BITS > BAND_W) ? SAMPLE_BITS : BAND_W) + 1;
	localparam int REM_W  = SAMPLE_BITS + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TRACK,
		S_BAND,
		S_DIV,
		S_SAT,
		S_OUT
	} state_t;

	state_t                   state_q;

	// Configuration registers
	logic [LEVEL_W-1:0]       pwm_max_q;
	logic [VOTE_W-1:0]        vote_limit_q;
	logic [BAND_W-1:0]        band_above_q;
	logic [BAND_W-1:0]        band_below_q;

	// Drive state
	logic                     drive_on_q;
	logic [TARGET_BITS-1:0]   target_q;
	logic [SAMPLE_BITS-1:0]   tracked_q;
	logic signed [VC_W-1:0]   vote_q;
	logic [SAMPLE_BITS-1:0]   divisor_q;
	logic [LEVEL_W-1:0]       level_q;
	logic [DITHER_BITS-1:0]   phase_q;
	logic [SAMPLE_BITS-1:0]   sample_q;

	// Divider registers
	logic [SAMPLE_BITS-1:0]   rem_q;
	logic [TARGET_BITS-1:0]   quo_q;
	logic [CNT_W-1:0]         cnt_q;

	// Output register
	logic                     out_valid_q;
	logic [CMP_W-1:0]         cmp_q;
	logic [LEVEL_W-1:0]       drv_q;

	logic                     in_xfer;
	logic                     out_free;
	logic                     out_load;

	logic signed [VX_W-1:0]   vote_ext;
	logic signed [VX_W-1:0]   vote_lim;
	logic signed [VX_W-1:0]   vote_dn;
	logic signed [VX_W-1:0]   vote_up;
	logic [SAMPLE_BITS-1:0]   tracked_nx;
	logic signed [VC_W-1:0]   vote_nx;

	logic                     band_out;
	logic [SAMPLE_BITS-1:0]   divisor_nx;

	logic [REM_W-1:0]         rem_sh;
	logic [REM_W-1:0]         rem_diff;
	logic                     quo_bit;
	logic [SAMPLE_BITS-1:0]   rem_nx;

	logic [LEVEL_W-1:0]       level_sat;
	logic [DITHER_BITS-1:0]   phase_inc;
	logic [CMP_W-1:0]         level_hi;
	logic                     dither_hit;

	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || !out_free;
	assign cfg_ready = 1'b1;

	// A new result enters the output register this cycle.
	assign out_load  = (state_q == S_IDLE && in_xfer && op != OP_SAMPLE) ||
	                   (state_q == S_OUT && out_free);

	assign out_valid     = out_valid_q;
	assign compare_value = cmp_q;
	assign drive_level   = drv_q;

	// Vote counting and single-step tracking of the battery value.
	always_comb begin
		vote_ext   = VX_W'(vote_q);
		vote_lim   = signed'(VX_W'(vote_limit_q));
		vote_dn    = vote_ext - VX_W'(1);
		vote_up    = vote_ext + VX_W'(1);
		tracked_nx = tracked_q;
		vote_nx    = vote_q;
		if (tracked_q > sample_q) begin
			if (vote_dn < -vote_lim) begin
				tracked_nx = tracked_q - SAMPLE_BITS'(1);
				vote_nx    = '0;
			end else begin
				vote_nx = vote_dn[VC_W-1:0];
			end
		end else if (tracked_q < sample_q) begin
			if (vote_up > vote_lim) begin
				tracked_nx = tracked_q + SAMPLE_BITS'(1);
				vote_nx    = '0;
			end else begin
				vote_nx = vote_up[VC_W-1:0];
			end
		end
	end

	// Divisor reloads when the tracked value leaves the band around it.
	always_comb begin
		band_out = (BW'(tracked_q) > BW'(divisor_q) + BW'(band_above_q)) ||
		           (BW'(tracked_q) + BW'(band_below_q) < BW'(divisor_q));
		divisor_nx = band_out ? tracked_q : divisor_q;
	end

	// One restoring division step per cycle.
	always_comb begin
		rem_sh   = {rem_q, quo_q[TARGET_BITS-1]};
		rem_diff = rem_sh - REM_W'(divisor_q);
		quo_bit  = rem_sh >= REM_W'(divisor_q);
		rem_nx   = quo_bit ? rem_diff[SAMPLE_BITS-1:0] : rem_sh[SAMPLE_BITS-1:0];
	end

	// Saturation and dithered compare value.
	always_comb begin
		level_sat  = (quo_q > TARGET_BITS'(pwm_max_q)) ? pwm_max_q : quo_q[LEVEL_W-1:0];
		phase_inc  = phase_q + DITHER_BITS'(1);
		level_hi   = CMP_W'(level_q >> DITHER_BITS);
		dither_hit = phase_inc < level_q[DITHER_BITS-1:0];
	end

	// Sequencer, state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pwm_max_q    <= PWM_MAX_RST;
			vote_limit_q <= VOTE_LIMIT_RST;
			band_above_q <= BAND_ABOVE_RST;
			band_below_q <= BAND_BELOW_RST;
			drive_on_q   <= 1'b0;
			target_q     <= '0;
			tracked_q    <= '0;
			vote_q       <= '0;
			divisor_q    <= '0;
			level_q      <= '0;
			phase_q      <= '0;
			sample_q     <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			cmp_q        <= '0;
			drv_q        <= '0;
		end else begin
			// Configuration writes
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_PWM_MAX:    pwm_max_q    <= cfg_data[LEVEL_W-1:0];
					CFG_VOTE_LIMIT: vote_limit_q <= cfg_data[VOTE_W-1:0];
					CFG_BAND_ABOVE: band_above_q <= cfg_data[BAND_W-1:0];
					CFG_BAND_BELOW: band_below_q <= cfg_data[BAND_W-1:0];
					default:        ;
				endcase
			end

			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						unique case (op)
							OP_SET: begin
								target_q   <= target_level;
								tracked_q  <= battery_sample;
								drive_on_q <= 1'b1;
							end
							OP_OFF: begin
								drive_on_q <= 1'b0;
							end
							OP_SAMPLE: begin
								sample_q <= battery_sample;
								state_q  <= S_TRACK;
							end
							OP_TICK: begin
								phase_q <= phase_inc;
							end
							default: ;
						endcase
						// Set, off and tick items answer at once; level is unchanged.
						if (op != OP_SAMPLE) begin
							out_valid_q <= 1'b1;
							cmp_q       <= level_hi + CMP_W'(op == OP_TICK && dither_hit);
							drv_q       <= level_q;
						end
					end
				end
				S_TRACK: begin
					if (!drive_on_q) begin
						quo_q   <= '0;
						state_q <= S_SAT;
					end else if (target_q < TARGET_BITS'(SMALL_TARGET)) begin
						quo_q   <= target_q;
						state_q <= S_SAT;
					end else begin
						tracked_q <= tracked_nx;
						vote_q    <= vote_nx;
						state_q   <= S_BAND;
					end
				end
				S_BAND: begin
					divisor_q <= divisor_nx;
					if (divisor_nx == '0) begin
						quo_q   <= '0;
						state_q <= S_SAT;
					end else begin
						rem_q   <= '0;
						quo_q   <= target_q;
						cnt_q   <= CNT_W'(TARGET_BITS - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_nx;
					quo_q <= {quo_q[TARGET_BITS-2:0], quo_bit};
					if (cnt_q == '0) begin
						state_q <= S_SAT;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_SAT: begin
					level_q <= level_sat;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cmp_q       <= level_hi;
						drv_q       <= level_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The partial remainder always stays below the divisor.
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < divisor_q)
		else $error("divider remainder reached the divisor");

	// The divider never runs on a zero divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> divisor_q != '0)
		else $error("divider started with zero divisor");

	// A sample transfer starts the tracking sequence.
	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && op == OP_SAMPLE |=> state_q == S_TRACK)
		else $error("sample transfer did not start the sequence");

	// After the saturation step the input is stalled.
	a_sample_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SAT |=> !in_stall == 1'b0)
		else $error("input taken while a sample result is pending");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for battery_compensated_pwm_drive with a built-in drive level predictor.
// Depends on bcpd_pkg and the battery_compensated_pwm_drive RTL; needs no files or arguments.

module testbench;
	import bcpd_pkg::*;

	localparam int TGT_W       = 24;
	localparam int SMP_W       = 10;
	localparam int DITHER_W    = 3;
	localparam int CYCLE_LIMIT = 1_000_000;

	// One expected result of the drive.
	typedef struct {
		logic [CMP_W-1:0]   cmp;
		logic [LEVEL_W-1:0] lvl;
	} drive_result_t;

	// Predicts the drive level and compare value, and checks them against the results.
	class drive_level_scoreboard;
		logic                 drive_on;
		logic [TGT_W-1:0]     target;
		logic [SMP_W-1:0]     tracked;
		int                   votes;
		logic [SMP_W-1:0]     divisor;
		logic [LEVEL_W-1:0]   level;
		logic [DITHER_W-1:0]  dither_phase;
		logic [LEVEL_W-1:0]   pwm_max;
		logic [VOTE_W-1:0]    vote_limit;
		logic [BAND_W-1:0]    band_above;
		logic [BAND_W-1:0]    band_below;
		drive_result_t        expected_results[$];
		int                   errors;

		function new();
			drive_on     = 1'b0;
			target       = '0;
			tracked      = '0;
			votes        = 0;
			divisor      = '0;
			level        = '0;
			dither_phase = '0;
			pwm_max      = PWM_MAX_RST;
			vote_limit   = VOTE_LIMIT_RST;
			band_above   = BAND_ABOVE_RST;
			band_below   = BAND_BELOW_RST;
			errors       = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
			CFG_PWM_MAX:    pwm_max = val[LEVEL_W-1:0];
			CFG_VOTE_LIMIT: vote_limit = val[VOTE_W-1:0];
			CFG_BAND_ABOVE: band_above = val[BAND_W-1:0];
			CFG_BAND_BELOW: band_below = val[BAND_W-1:0];
			endcase
		endfunction

		// Advance the predicted state by one accepted item and queue its result.
		function void note_item(op_t code, logic [TGT_W-1:0] tl, logic [SMP_W-1:0] smp);
			int lim;
			int trk;
			int dv;
			longint unsigned quot;
			drive_result_t exp_r;
			case (code)
			OP_SET: begin
				target   = tl;
				tracked  = smp;
				drive_on = 1'b1;
			end
			OP_OFF: drive_on = 1'b0;
			OP_SAMPLE: begin
				if (!drive_on) begin
					level = '0;
				end else if (target < SMALL_TARGET) begin
					level = (target > pwm_max) ? pwm_max : target[LEVEL_W-1:0];
				end else begin
					// The tracked value steps only once the votes exceed the limit.
					lim = vote_limit;
					if (tracked > smp) begin
						votes--;
						if (votes < -lim) begin
							tracked = tracked - 1'b1;
							votes   = 0;
						end
					end else if (tracked < smp) begin
						votes++;
						if (votes > lim) begin
							tracked = tracked + 1'b1;
							votes   = 0;
						end
					end
					// The divisor reloads only when the tracked value leaves its band.
					trk = tracked;
					dv  = divisor;
					if (trk > dv + int'(band_above) || trk + int'(band_below) < dv)
						divisor = tracked;
					if (divisor == 0)
						quot = 0;
					else
						quot = target / divisor;
					level = (quot > pwm_max) ? pwm_max : quot[LEVEL_W-1:0];
				end
			end
			OP_TICK: dither_phase = dither_phase + 1'b1;
			endcase
			exp_r.cmp = CMP_W'(level >> DITHER_W);
			if (code == OP_TICK && dither_phase < level[DITHER_W-1:0])
				exp_r.cmp = exp_r.cmp + 1'b1;
			exp_r.lvl = level;
			expected_results.push_back(exp_r);
		endfunction

		function void check_result(logic [CMP_W-1:0] cmp, logic [LEVEL_W-1:0] lvl);
			drive_result_t exp_r;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, compare_value %0d drive_level %0d",
					$time, cmp, lvl);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (cmp !== exp_r.cmp) begin
					$display("%0t: compare_value expected %0d, actual %0d",
						$time, exp_r.cmp, cmp);
					errors++;
				end
				if (lvl !== exp_r.lvl) begin
					$display("%0t: drive_level expected %0d, actual %0d",
						$time, exp_r.lvl, lvl);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	op_t                 op;
	logic [TGT_W-1:0]    target_level;
	logic [SMP_W-1:0]    battery_sample;
	logic                out_valid;
	logic                out_stall;
	logic [CMP_W-1:0]    compare_value;
	logic [LEVEL_W-1:0]  drive_level;
	logic                cfg_valid;
	logic                cfg_ready;
	cfg_idx_t            cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	drive_level_scoreboard drive_sb = new();
	int  cycle_count  = 0;
	int  results_seen = 0;
	bit  no_idle      = 1'b0;

	battery_compensated_pwm_drive u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.target_level   (target_level),
		.battery_sample (battery_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.compare_value  (compare_value),
		.drive_level    (drive_level),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("battery_compensated_pwm_drive test failed");
			$finish;
		end
	end

	// Check every result transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			drive_sb.check_result(compare_value, drive_level);
			results_seen++;
		end
	end

	// Idle lengths: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int clamp_sample(int v);
		return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
	endfunction

	// Receiver back-pressure, with a long hold now and then so the block fills up.
	initial begin : result_backpressure
		int hold;
		int run;
		int next_hold_mark;
		next_hold_mark = 400;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_seen >= next_hold_mark) begin
				hold = 250;
				next_hold_mark += 700;
			end else begin
				hold = no_idle ? 0 : pick_gap();
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
			repeat (run) @(posedge clk);
		end
	end

	// Offer one item and wait for its transfer.
	task automatic send_item(op_t code, logic [TGT_W-1:0] tl, logic [SMP_W-1:0] smp);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		op             <= code;
		target_level   <= tl;
		battery_sample <= smp;
		do @(posedge clk); while (in_stall);
		drive_sb.note_item(code, tl, smp);
	endtask

	// Drop valid and wait until every predicted result has transferred.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (drive_sb.pending() != 0)
			@(posedge clk);
	endtask

	// Register write; valid stays high for a following write.
	task automatic reg_write(cfg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		drive_sb.write_reg(idx, val);
	endtask

	task automatic set_config(logic [LEVEL_W-1:0] pm, logic [VOTE_W-1:0] vl,
			logic [BAND_W-1:0] ba, logic [BAND_W-1:0] bb);
		reg_write(CFG_PWM_MAX, CFG_W'(pm));
		reg_write(CFG_VOTE_LIMIT, CFG_W'(vl));
		reg_write(CFG_BAND_ABOVE, CFG_W'(ba));
		reg_write(CFG_BAND_BELOW, CFG_W'(bb));
		cfg_valid <= 1'b0;
	endtask

	// Extremes, every operation and the special cases, under the reset settings.
	task automatic run_directed();
		send_item(OP_SAMPLE, '0, '0);
		send_item(OP_TICK, '1, '1);
		send_item(OP_SET, '1, '1);
		// Equal sample; the divisor loads and the level saturates.
		send_item(OP_SAMPLE, '0, '1);
		send_item(OP_SAMPLE, '0, '0);
		send_item(OP_TICK, '0, '0);
		// Small target passes straight through, then a full dither cycle.
		send_item(OP_SET, 24'd5, 10'd200);
		send_item(OP_SAMPLE, '0, '0);
		repeat (8) send_item(OP_TICK, TGT_W'($urandom), SMP_W'($urandom));
		// Tracked value far below the divisor reloads it to zero.
		send_item(OP_SET, 24'd8, '0);
		send_item(OP_SAMPLE, '0, '0);
		send_item(OP_SET, 24'd1000000, 10'd500);
		send_item(OP_SAMPLE, '0, 10'd500);
		send_item(OP_TICK, '0, '0);
		// A sample with the drive off clears the level.
		send_item(OP_OFF, '1, '1);
		send_item(OP_SAMPLE, '0, 10'd500);
		send_item(OP_TICK, '1, '1);
	endtask

	// Set-target sequences followed by drifting samples, ticks and some noise.
	task automatic run_phase(int n_items);
		int sent;
		int len;
		int k;
		int r;
		int base;
		int dir;
		int offs;
		int smp;
		logic [TGT_W-1:0] tgt;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
			0:       tgt = TGT_W'($urandom_range(0, SMALL_TARGET - 1));
			1:       tgt = '1;
			2, 3:    tgt = TGT_W'($urandom);
			default: tgt = TGT_W'($urandom_range(SMALL_TARGET, 1500000));
			endcase
			case ($urandom_range(0, 7))
			0:       base = 0;
			1:       base = 1023;
			default: base = $urandom_range(0, 1023);
			endcase
			dir = $urandom_range(0, 1) ? 1 : -1;
			if ($urandom_range(0, 5) == 0)
				no_idle = ~no_idle;
			send_item(OP_SET, tgt, SMP_W'(base));
			sent++;
			len = $urandom_range(10, 140);
			for (k = 0; k < len && sent < n_items; k++) begin
				r = $urandom_range(0, 99);
				if ($urandom_range(0, 39) == 0)
					dir = -dir;
				if (r < 66) begin
					if ($urandom_range(0, 15) == 0) begin
						offs = $urandom_range(0, 8);
						base = clamp_sample(base + dir * offs);
					end
					offs = $urandom_range(0, 24);
					smp = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023) :
						clamp_sample(base + dir * offs);
					send_item(OP_SAMPLE, TGT_W'($urandom), SMP_W'(smp));
				end else if (r < 88) begin
					send_item(OP_TICK, TGT_W'($urandom), SMP_W'($urandom));
				end else if (r < 92) begin
					send_item(OP_OFF, TGT_W'($urandom), SMP_W'($urandom));
				end else begin
					send_item(op_t'($urandom_range(OP_SET, OP_TICK)), TGT_W'($urandom),
						SMP_W'($urandom));
				end
				sent++;
			end
		end
	endtask

	// Reset, directed part, then random phases under several register settings.
	initial begin : stimulus
		int ph;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		op             = OP_SET;
		target_level   = '0;
		battery_sample = '0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_PWM_MAX;
		cfg_data       = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_idle();

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
			0: set_config(11'h7FF, 6'd0, 8'd0, 8'd0);
			1: set_config(11'd0, 6'h3F, 8'hFF, 8'hFF);
			2: set_config(PWM_MAX_RST, VOTE_LIMIT_RST, BAND_ABOVE_RST, BAND_BELOW_RST);
			3: set_config(11'd1000, 6'd1, 8'd1, 8'd7);
			4: set_config(11'd5, 6'd2, 8'd3, 8'd0);
			default: set_config(LEVEL_W'($urandom_range(0, 2047)),
				VOTE_W'($urandom_range(0, 63)),
				BAND_W'($urandom_range(0, 12)), BAND_W'($urandom_range(0, 12)));
			endcase
			no_idle = (ph == 2);
			run_phase(180);
			wait_idle();
		end

		// Allow for any stray result after the last one expected.
		repeat (40) @(posedge clk);
		if (drive_sb.errors == 0 && drive_sb.pending() == 0)
			$display("battery_compensated_pwm_drive test passed");
		else
			$display("battery_compensated_pwm_drive test failed");
		$finish;
	end

endmodule
